// ===== src/dsh_pkg.sv =====
// shared types and constants for the defect score hash table
// used by dsh_cell and defect_score_hash_table; no dependencies
`timescale 1ns / 1ps

package dsh_pkg;

    localparam logic [15:0] EMPTY_KEY = 16'hFFFF;
    localparam logic [31:0] HASH_MUL_X = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_Y = 32'd2246822519;

    localparam logic [1:0] STATUS_APPLIED = 2'd0;
    localparam logic [1:0] STATUS_IGNORED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [2:0] REG_CELL_SIZE     = 3'd0;
    localparam logic [2:0] REG_SCORE_FLOOR   = 3'd1;
    localparam logic [2:0] REG_SCORE_CEILING = 3'd2;
    localparam logic [2:0] REG_CONFIRM_LEVEL = 3'd3;
    localparam logic [2:0] REG_CLEAR_AMOUNT  = 3'd4;
    localparam logic [2:0] REG_DECAY_PERIOD  = 3'd5;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_CONFIRM = 2'd1,
        REQ_SUSPECT = 2'd2,
        REQ_QUERY   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_HASH,
        ST_MOD,
        ST_PROBE,
        ST_TICK,
        ST_RESP
    } state_t;

    // probe request travelling along the ring of cells
    typedef struct packed {
        logic        valid;
        req_t        req;
        logic [15:0] kx;
        logic [15:0] ky;
    } tok_t;

    // what a cell reports when a probe ends there
    typedef struct packed {
        logic       done;
        logic       is_defect;
        logic [1:0] status;
        logic       inserted;
    } cell_res_t;

    // score limits handed to every cell
    typedef struct packed {
        logic signed [15:0] floor;
        logic [14:0]        ceiling;
        logic signed [15:0] level;
        logic [14:0]        clear;
    } score_cfg_t;

endpackage

// ===== src/dsh_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on nothing outside this file
`timescale 1ns / 1ps

module dsh_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] trial;
    logic        ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[31]};
        ge        = trial >= {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = 5'(cnt_reg + 5'd1);
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/dsh_cell.sv =====
// one table slot: key, score and a probe stage that passes to the next slot
// depends on dsh_pkg
`timescale 1ns / 1ps

module dsh_cell #(
    parameter int SLOTS = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dsh_pkg::score_cfg_t      cfg,
    input  logic                     decay,
    input  logic                     inj_sel,
    input  dsh_pkg::tok_t            inj_tok,
    input  dsh_pkg::tok_t            tok_in,
    input  logic [$clog2(SLOTS)-1:0] hops_in,
    output dsh_pkg::tok_t            tok_out,
    output logic [$clog2(SLOTS)-1:0] hops_out,
    output dsh_pkg::cell_res_t       res
);

    localparam int HW = $clog2(SLOTS);

    logic [15:0]        key_x_reg, key_x_next;
    logic [15:0]        key_y_reg, key_y_next;
    logic signed [15:0] score_reg, score_next;
    dsh_pkg::tok_t      tok_reg, tok_next;
    logic [HW-1:0]      hops_reg, hops_next;

    dsh_pkg::tok_t      cur;
    logic [HW-1:0]      cur_hops;
    logic               match, empty, last;
    logic signed [16:0] dec_v, inc_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_x_reg <= dsh_pkg::EMPTY_KEY;
            key_y_reg <= dsh_pkg::EMPTY_KEY;
            score_reg <= '0;
            tok_reg   <= '0;
        end else begin
            key_x_reg <= key_x_next;
            key_y_reg <= key_y_next;
            score_reg <= score_next;
            tok_reg   <= tok_next;
        end
        hops_reg <= hops_next;
    end

    always_comb begin
        cur      = inj_sel ? inj_tok : tok_in;
        cur_hops = inj_sel ? '0 : hops_in;
        match    = (key_x_reg == cur.kx) && (key_y_reg == cur.ky);
        empty    = key_x_reg == dsh_pkg::EMPTY_KEY;
        last     = cur_hops == HW'(SLOTS - 1);
        dec_v    = 17'(signed'({score_reg[15], score_reg})) - 17'(signed'({2'b00, cfg.clear}));
        inc_v    = 17'(signed'({score_reg[15], score_reg})) + 17'sd1;

        key_x_next = key_x_reg;
        key_y_next = key_y_reg;
        score_next = score_reg;
        tok_next   = '0;
        hops_next  = HW'(cur_hops + HW'(1));
        res        = '0;

        if (cur.valid) begin
            if (match) begin
                res.done   = 1'b1;
                res.status = dsh_pkg::STATUS_APPLIED;
                unique case (cur.req)
                    dsh_pkg::REQ_CONFIRM: begin
                        score_next = (dec_v < 17'(signed'(cfg.floor))) ? cfg.floor
                                                                       : dec_v[15:0];
                    end
                    dsh_pkg::REQ_SUSPECT: begin
                        score_next = (inc_v > 17'(signed'({2'b00, cfg.ceiling})))
                                   ? signed'({1'b0, cfg.ceiling}) : inc_v[15:0];
                    end
                    dsh_pkg::REQ_QUERY: begin
                        res.is_defect = score_reg >= cfg.level;
                    end
                    default: ;
                endcase
            end else if (empty) begin
                res.done = 1'b1;
                if (cur.req == dsh_pkg::REQ_SUSPECT) begin
                    key_x_next   = cur.kx;
                    key_y_next   = cur.ky;
                    // fresh entry starts at zero then takes one step up
                    score_next   = (cfg.ceiling == 15'd0) ? 16'sd0 : 16'sd1;
                    res.inserted = 1'b1;
                    res.status   = dsh_pkg::STATUS_APPLIED;
                end else begin
                    res.status = dsh_pkg::STATUS_IGNORED;
                end
            end else if (last) begin
                res.done   = 1'b1;
                res.status = (cur.req == dsh_pkg::REQ_SUSPECT) ? dsh_pkg::STATUS_FULL
                                                               : dsh_pkg::STATUS_IGNORED;
            end else begin
                tok_next = cur;
            end
        end else if (decay && !empty) begin
            if (score_reg > 16'sd0) begin
                score_next = 16'(score_reg - 16'sd1);
            end else if (score_reg < 16'sd0) begin
                score_next = 16'(score_reg + 16'sd1);
            end
        end
    end

    assign tok_out  = tok_reg;
    assign hops_out = hops_reg;

endmodule

// ===== src/defect_score_hash_table.sv =====
// defect score hash table: top level with request sequencer and ring of slot cells
// depends on dsh_pkg, dsh_div and dsh_cell
//
// usage:
//  - requests enter on s_axis (tuser = request kind, tdata = pos_x, pos_y);
//    one result per request leaves on m_axis
//  - registers are written on the cfg channel; the user must write them only while no
//    request is open, the block itself does not enforce it
//  - a frame tick: the 32-step division of the frame count by the decay period, then
//    the result; at a zero remainder the score of every occupied slot steps toward
//    zero at once while the result waits
//  - other requests: the two cell divisions, the hash, taking the home slot from the
//    low hash bits (TABLE_SLOTS is a power of two), then the probe along the ring,
//    visiting 1 to TABLE_SLOTS slots; both divisions use the shared serial divider
//  - an invalid key (65535 after division) skips the hash and probe, status ignored
//  - one request is open at a time; s_axis_tready is low until the result has
//    been taken, the next request is accepted in the following cycle at the earliest
//  - the result register holds while m_axis_tready is low
//  - reset clears all slots to empty and loads register defaults
`timescale 1ns / 1ps

module defect_score_hash_table #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // is_defect[0], status[2:1], tracked_count[11:3], frames_observed[43:12], zero
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int HW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    dsh_pkg::state_t    state_reg, state_next;
    dsh_pkg::req_t      req_reg, req_next;
    logic [15:0]        py_reg, py_next;
    logic [15:0]        kx_reg, kx_next;
    logic [15:0]        ky_reg, ky_next;
    logic [31:0]        mixed_reg, mixed_next;
    logic [HW-1:0]      home_reg, home_next;
    logic               inject_reg, inject_next;
    logic               decay_reg, decay_next;
    logic [31:0]        frame_reg, frame_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic               is_def_reg, is_def_next;
    logic [1:0]         status_reg, status_next;

    logic [7:0]         cell_size_reg;
    logic signed [15:0] floor_reg;
    logic [14:0]        ceiling_reg;
    logic signed [15:0] level_reg;
    logic [14:0]        clear_reg;
    logic [15:0]        period_reg;

    logic               div_start, div_done;
    logic [31:0]        div_dvd, div_quo;
    logic [15:0]        div_dvs, div_rem, cell_dvs;
    logic [31:0]        prod_x, prod_y;

    dsh_pkg::tok_t      tok_w [TABLE_SLOTS];
    logic [HW-1:0]      hops_w [TABLE_SLOTS];
    dsh_pkg::cell_res_t res_w [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] done_vec;
    dsh_pkg::cell_res_t res_any;
    dsh_pkg::tok_t      inj_tok;
    dsh_pkg::score_cfg_t score_cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dsh_pkg::ST_IDLE;
            inject_reg    <= 1'b0;
            decay_reg     <= 1'b0;
            frame_reg     <= '0;
            occ_reg       <= '0;
            cell_size_reg <= 8'd4;
            floor_reg     <= -16'sd8;
            ceiling_reg   <= 15'd16;
            level_reg     <= 16'sd4;
            clear_reg     <= 15'd4;
            period_reg    <= 16'd16;
        end else begin
            state_reg  <= state_next;
            inject_reg <= inject_next;
            decay_reg  <= decay_next;
            frame_reg  <= frame_next;
            occ_reg    <= occ_next;
            if (cfg_valid) begin
                unique case (cfg_addr)
                    dsh_pkg::REG_CELL_SIZE:     cell_size_reg <= cfg_wdata[7:0];
                    dsh_pkg::REG_SCORE_FLOOR:   floor_reg     <= signed'(cfg_wdata);
                    dsh_pkg::REG_SCORE_CEILING: ceiling_reg   <= cfg_wdata[14:0];
                    dsh_pkg::REG_CONFIRM_LEVEL: level_reg     <= signed'(cfg_wdata);
                    dsh_pkg::REG_CLEAR_AMOUNT:  clear_reg     <= cfg_wdata[14:0];
                    dsh_pkg::REG_DECAY_PERIOD:  period_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        req_reg    <= req_next;
        py_reg     <= py_next;
        kx_reg     <= kx_next;
        ky_reg     <= ky_next;
        mixed_reg  <= mixed_next;
        home_reg   <= home_next;
        is_def_reg <= is_def_next;
        status_reg <= status_next;
    end

    assign cfg_ready = 1'b1;
    assign cell_dvs  = {8'd0, (cell_size_reg == 8'd0) ? 8'd1 : cell_size_reg};
    assign prod_x    = kx_reg * dsh_pkg::HASH_MUL_X;
    assign prod_y    = ky_reg * dsh_pkg::HASH_MUL_Y;

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        py_next     = py_reg;
        kx_next     = kx_reg;
        ky_next     = ky_reg;
        mixed_next  = mixed_reg;
        home_next   = home_reg;
        inject_next = 1'b0;
        decay_next  = 1'b0;
        frame_next  = frame_reg;
        occ_next    = occ_reg;
        is_def_next = is_def_reg;
        status_next = status_reg;
        div_start   = 1'b0;
        div_dvd     = {16'd0, s_axis_tdata[15:0]};
        div_dvs     = cell_dvs;

        unique case (state_reg)
            dsh_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    req_next    = dsh_pkg::req_t'(s_axis_tuser);
                    py_next     = s_axis_tdata[31:16];
                    is_def_next = 1'b0;
                    status_next = dsh_pkg::STATUS_APPLIED;
                    div_start   = 1'b1;
                    if (dsh_pkg::req_t'(s_axis_tuser) == dsh_pkg::REQ_TICK) begin
                        frame_next = 32'(frame_reg + 32'd1);
                        div_dvd    = 32'(frame_reg + 32'd1);
                        div_dvs    = (period_reg == 16'd0) ? 16'd1 : period_reg;
                        state_next = dsh_pkg::ST_TICK;
                    end else begin
                        state_next = dsh_pkg::ST_DIVX;
                    end
                end
            end
            dsh_pkg::ST_DIVX: begin
                if (div_done) begin
                    kx_next    = div_quo[15:0];
                    div_start  = 1'b1;
                    div_dvd    = {16'd0, py_reg};
                    state_next = dsh_pkg::ST_DIVY;
                end
            end
            dsh_pkg::ST_DIVY: begin
                if (div_done) begin
                    ky_next = div_quo[15:0];
                    if (kx_reg == dsh_pkg::EMPTY_KEY || div_quo[15:0] == dsh_pkg::EMPTY_KEY) begin
                        status_next = dsh_pkg::STATUS_IGNORED;
                        state_next  = dsh_pkg::ST_RESP;
                    end else begin
                        state_next = dsh_pkg::ST_HASH;
                    end
                end
            end
            dsh_pkg::ST_HASH: begin
                mixed_next = prod_x ^ prod_y;
                state_next = dsh_pkg::ST_MOD;
            end
            dsh_pkg::ST_MOD: begin
                // power-of-two table, so the home slot is the low hash bits
                home_next   = mixed_reg[HW-1:0];
                inject_next = 1'b1;
                state_next  = dsh_pkg::ST_PROBE;
            end
            dsh_pkg::ST_PROBE: begin
                if (res_any.done) begin
                    is_def_next = res_any.is_defect;
                    status_next = res_any.status;
                    if (res_any.inserted) begin
                        occ_next = CW'(occ_reg + CW'(1));
                    end
                    state_next = dsh_pkg::ST_RESP;
                end
            end
            dsh_pkg::ST_TICK: begin
                if (div_done) begin
                    decay_next = div_rem == 16'd0;
                    state_next = dsh_pkg::ST_RESP;
                end
            end
            dsh_pkg::ST_RESP: begin
                if (m_axis_tready) begin
                    state_next = dsh_pkg::ST_IDLE;
                end
            end
            default: state_next = dsh_pkg::ST_IDLE;
        endcase
    end

    dsh_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        inj_tok.valid     = inject_reg;
        inj_tok.req       = req_reg;
        inj_tok.kx        = kx_reg;
        inj_tok.ky        = ky_reg;
        score_cfg.floor   = floor_reg;
        score_cfg.ceiling = ceiling_reg;
        score_cfg.level   = level_reg;
        score_cfg.clear   = clear_reg;
    end

    for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
        localparam int PREV = (i + TABLE_SLOTS - 1) % TABLE_SLOTS;
        dsh_cell #(
            .SLOTS (TABLE_SLOTS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cfg      (score_cfg),
            .decay    (decay_reg),
            .inj_sel  (inject_reg && (home_reg == HW'(i))),
            .inj_tok  (inj_tok),
            .tok_in   (tok_w[PREV]),
            .hops_in  (hops_w[PREV]),
            .tok_out  (tok_w[i]),
            .hops_out (hops_w[i]),
            .res      (res_w[i])
        );
        assign done_vec[i] = res_w[i].done;
    end

    // only the cell that ends the probe reports, so an or across the ring picks it
    always_comb begin
        res_any = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            res_any = res_any | res_w[i];
        end
    end

    assign s_axis_tready = state_reg == dsh_pkg::ST_IDLE;
    assign m_axis_tvalid = state_reg == dsh_pkg::ST_RESP;
    assign m_axis_tdata  = {4'd0, frame_reg, 9'(occ_reg), status_reg, is_def_reg};

    a_one_cell_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(done_vec))
        else $error("more than one cell ended a probe");
    a_done_in_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        res_any.done |-> state_reg == dsh_pkg::ST_PROBE)
        else $error("probe ended outside probe state");
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(TABLE_SLOTS))
        else $error("occupied count beyond table size");
    a_decay_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        decay_reg |-> $past(state_reg) == dsh_pkg::ST_TICK)
        else $error("decay outside frame tick");

endmodule
